[sv/smbus_slave_register_file_defines.svh]
// ----------------------------------------------------------------------------
// SMBus slave register file assertion macros
// Shared property shorthands for the register file modules.
// ----------------------------------------------------------------------------
`ifndef SMBUS_SLAVE_REGISTER_FILE_DEFINES_SVH
`define SMBUS_SLAVE_REGISTER_FILE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define SRF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define SRF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[sv/smbus_rf_pkg.sv]
// ----------------------------------------------------------------------------
// SMBus slave register file package
// Event codes, default sizes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smbus_rf_pkg;

	localparam int STORE_DEPTH_DEF = 64;

	// Bus event codes carried on func.
	localparam logic [2:0] FUNC_ADDR_ACK = 3'd0;
	localparam logic [2:0] FUNC_DATA     = 3'd1;
	localparam logic [2:0] FUNC_STOP     = 3'd2;
	localparam logic [2:0] FUNC_TX_REQ   = 3'd3;
	localparam logic [2:0] FUNC_BUS_ERR  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;     // an event word is taken this cycle
		logic capture;  // store read data has arrived
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;  // the offered event is a transmit request
	} dp_status_t;

endpackage

[sv/smbus_rf_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbus_rf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/smbus_rf_ctrl.sv]
// ----------------------------------------------------------------------------
// SMBus slave register file controller
// Sequences one event word at a time through execute, an optional store read and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "smbus_slave_register_file_defines.svh"

module smbus_rf_ctrl
	import smbus_rf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       event_valid,
	output logic       event_stall,
	output logic       result_valid,
	input  logic       result_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_READ   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign event_stall  = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_RESULT);
	assign cmd.exec     = event_valid && (state_q == ST_IDLE);
	assign cmd.capture  = (state_q == ST_READ);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (event_valid) begin
					state_d = status.is_read ? ST_READ : ST_RESULT;
				end
			end
			ST_READ: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SRF_ASSERT_NXT(a_read_goes_to_read, cmd.exec && status.is_read, state_q == ST_READ, "transmit request did not start a store read")
	`SRF_ASSERT_NXT(a_exec_goes_to_result, cmd.exec && !status.is_read, result_valid, "event result not presented after execute")
	`SRF_ASSERT_NXT(a_result_held, result_valid && result_stall, result_valid, "stalled result word was dropped")

endmodule

[sv/smbus_rf_dp.sv]
// ----------------------------------------------------------------------------
// SMBus slave register file datapath
// Pointer, byte counter, write enable, byte store and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbus_rf_dp
	import smbus_rf_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status,
	input  logic       cfg_valid,
	input  logic       cfg_data,
	input  logic [2:0] func,
	input  logic [7:0] data_byte,
	output logic [7:0] read_data,
	output logic       read_valid,
	output logic       command_valid,
	output logic [7:0] command_code,
	output logic       block_done,
	output logic       recover_stop
);

	localparam int         ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [8:0] DEPTH_L = 9'(STORE_DEPTH);

	logic [7:0]        pointer_q;
	logic [1:0]        counter_q;
	logic              write_enable_q;
	logic [STORE_DEPTH-1:0] written_q;
	logic              rd_hit_q;

	logic [7:0]        read_data_q;
	logic              read_valid_q;
	logic              command_valid_q;
	logic [7:0]        command_code_q;
	logic              block_done_q;
	logic              recover_stop_q;

	logic              in_range;
	logic [ADDR_W-1:0] addr;
	logic              is_data;
	logic              is_tx;
	logic              block_byte;
	logic              ram_we;
	logic [7:0]        ram_rdata;

	assign in_range   = ({1'b0, pointer_q} < DEPTH_L);
	assign addr       = pointer_q[ADDR_W-1:0];
	assign is_data    = (func == FUNC_DATA);
	assign is_tx      = (func == FUNC_TX_REQ);
	assign block_byte = is_data && (counter_q[1] == 1'b1) && write_enable_q;
	assign ram_we     = cmd.exec && block_byte && in_range;

	assign status.is_read = is_tx;

	smbus_rf_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (addr),
		.wr_data (data_byte),
		.rd_en   (cmd.exec && is_tx),
		.rd_addr (addr),
		.rd_data (ram_rdata)
	);

	// Control state: pointer, counter, write enable and per-entry written flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_q      <= '0;
			counter_q      <= '0;
			write_enable_q <= 1'b1;
			written_q      <= '0;
		end else begin
			if (cfg_valid) begin
				write_enable_q <= cfg_data;
			end
			if (ram_we) begin
				written_q[addr] <= 1'b1;
			end
			if (cmd.exec) begin
				case (func)
					FUNC_ADDR_ACK: begin
						counter_q <= '0;
					end
					FUNC_DATA: begin
						if (counter_q == 2'd0) begin
							pointer_q <= data_byte;
						end else if (block_byte) begin
							pointer_q <= pointer_q + 8'd1;
						end
						if (counter_q != 2'd3) begin
							counter_q <= counter_q + 2'd1;
						end
					end
					FUNC_TX_REQ: begin
						if (in_range) begin
							pointer_q <= pointer_q + 8'd1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result word; read data is filled in from the store in the following cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_hit_q        <= in_range && written_q[addr];
			read_data_q     <= '0;
			read_valid_q    <= is_tx;
			command_valid_q <= (func == FUNC_STOP) && (counter_q == 2'd1);
			command_code_q  <= ((func == FUNC_STOP) && (counter_q == 2'd1)) ? pointer_q : 8'd0;
			block_done_q    <= (func == FUNC_STOP) && (counter_q == 2'd3);
			recover_stop_q  <= (func == FUNC_BUS_ERR);
		end
		if (cmd.capture) begin
			read_data_q <= rd_hit_q ? ram_rdata : 8'd0;
		end
	end

	assign read_data     = read_data_q;
	assign read_valid    = read_valid_q;
	assign command_valid = command_valid_q;
	assign command_code  = command_code_q;
	assign block_done    = block_done_q;
	assign recover_stop  = recover_stop_q;

endmodule

[sv/smbus_slave_register_file.sv]
// ----------------------------------------------------------------------------
// SMBus slave register file
// Target-side event handler with a register pointer in front of a byte store.
// ----------------------------------------------------------------------------
// Each event word (func, data_byte) produces exactly one result word. The
// block handles one event at a time. An event that is not a transmit request
// presents its result word in the cycle after it is accepted. A transmit
// request passes through a store read state first, because the byte store is
// a RAM with a registered read port and the read data is fetched in a state
// of its own. The result word is held for as long as result_stall is high.
// The block accepts the next event in the cycle after the current result word
// has been taken. The store reads as zero after reset without a clearing
// pass: a flag per entry, cleared by reset, marks the entries that have been
// written since. The write_enable register resets to one and is written
// through the cfg port, which is always ready; it should be written only
// while no event is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbus_slave_register_file
	import smbus_rf_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration write channel.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	// Event channel.
	input  logic       event_valid,
	output logic       event_stall,
	input  logic [2:0] func,
	input  logic [7:0] data_byte,
	// Result channel.
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] read_data,
	output logic       read_valid,
	output logic       command_valid,
	output logic [7:0] command_code,
	output logic       block_done,
	output logic       recover_stop
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// The register write is a plain register load, so the port never stalls.
	assign cfg_ready = 1'b1;

	// The controller steps each event through execute, an optional store read,
	// and the result hand-off.
	smbus_rf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// The datapath holds the pointer, the byte counter, the store and the
	// result registers that drive the result channel directly.
	smbus_rf_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.func          (func),
		.data_byte     (data_byte),
		.read_data     (read_data),
		.read_valid    (read_valid),
		.command_valid (command_valid),
		.command_code  (command_code),
		.block_done    (block_done),
		.recover_stop  (recover_stop)
	);

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMBus slave register file testbench
// The testbench sends bus event words into the block and checks every result
// word against a cycle-free model of the pointer, the byte counter and the
// byte store. A short table of directed words comes first. Random write,
// command and read transfers follow, mixed with noise, under several
// write_enable settings and with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb;
	import smbus_rf_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 12;
	localparam int STORE_DEPTH     = STORE_DEPTH_DEF;
	// Idle wait after the last result word, for the block to settle.
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int PHASES          = 6;
	localparam int WORDS_PER_PHASE = 250;
	localparam int DIRECTED_ROWS   = 26;
	localparam int REPORT_LIMIT    = 10;

	// Event codes that the package leaves unnamed; the block must ignore them.
	localparam logic [2:0] FUNC_OTHER      = 3'd5;
	localparam logic [2:0] FUNC_OTHER_LAST = 3'd7;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic       command_valid;
		logic [7:0] command_code;
		logic       block_done;
		logic       recover_stop;
	} result_word_t;

	localparam result_word_t NO_REPORT = '0;

	// One row of the directed table. When typed is set, want is the result
	// word read straight off the spec; otherwise the model supplies it.
	typedef struct {
		logic [2:0]   code;
		logic [7:0]   payload;
		bit           typed;
		result_word_t want;
	} stim_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// Every input of the block has a known value from time zero.
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic       cfg_data     = 1'b1;
	logic       event_valid  = 1'b0;
	logic       event_stall;
	logic [2:0] func         = FUNC_ADDR_ACK;
	logic [7:0] data_byte    = 8'h00;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] read_data;
	logic       read_valid;
	logic       command_valid;
	logic [7:0] command_code;
	logic       block_done;
	logic       recover_stop;

	// Model state: a copy of the store, the pointer, the byte counter and the
	// write_enable register, updated at the edge where each word is accepted.
	logic [7:0]   store_image [STORE_DEPTH];
	logic [7:0]   pointer_model;
	logic [1:0]   data_count_model;
	logic         write_enable_model;
	result_word_t expected_results [$];

	int unsigned  cycle_count    = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  results_seen   = 0;
	int unsigned  words_sent     = 0;

	// Sender pacing: in bursty mode the sender drops valid for a random gap
	// after each burst; otherwise it keeps valid high back to back.
	bit           bursty        = 1'b0;
	bit           sender_active = 1'b0;
	int unsigned  burst_left    = 1;

	stall_mode_t  stall_mode = STALL_NONE;
	int unsigned  stall_hold = 0;

	smbus_slave_register_file #(
		.STORE_DEPTH(STORE_DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.func         (func),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.read_valid   (read_valid),
		.command_valid(command_valid),
		.command_code (command_code),
		.block_done   (block_done),
		.recover_stop (recover_stop)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Runaway guard: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("smbus_slave_register_file verification failed");
			$finish;
		end
	end

	// Applies one bus event to the model and returns the result word that
	// the block should produce for it.
	function automatic result_word_t predict_event(input logic [2:0] code,
			input logic [7:0] payload);
		result_word_t r;
		r = NO_REPORT;
		case (code)
			FUNC_ADDR_ACK: begin
				data_count_model = 2'd0;
			end
			FUNC_DATA: begin
				// First byte loads the pointer, the second (block length) is
				// dropped, and every later byte is a block-write byte when write_enable is set.
				if (data_count_model == 2'd0) begin
					pointer_model = payload;
				end else if (data_count_model >= 2'd2 && write_enable_model) begin
					// Out-of-range bytes are lost but the pointer still moves.
					if (pointer_model < STORE_DEPTH) begin
						store_image[pointer_model] = payload;
					end
					pointer_model = pointer_model + 8'd1;
				end
				if (data_count_model != 2'd3) begin
					data_count_model = data_count_model + 2'd1;
				end
			end
			FUNC_STOP: begin
				// The counter survives a stop, so a repeated stop repeats
				// the same report.
				if (data_count_model == 2'd1) begin
					r.command_valid = 1'b1;
					r.command_code  = pointer_model;
				end else if (data_count_model == 2'd3) begin
					r.block_done = 1'b1;
				end
			end
			FUNC_TX_REQ: begin
				// An out-of-range pointer answers zero and stays put.
				r.read_valid = 1'b1;
				if (pointer_model < STORE_DEPTH) begin
					r.read_data   = store_image[pointer_model];
					pointer_model = pointer_model + 8'd1;
				end
			end
			FUNC_BUS_ERR: begin
				r.recover_stop = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic result_word_t word_of(input logic [7:0] rd, input logic rv,
			input logic cv, input logic [7:0] cc, input logic bd, input logic rs);
		return {rd, rv, cv, cc, bd, rs};
	endfunction

	// Pointers mostly land inside the store so that reads find written data.
	// The rest sit at the store edge or anywhere, including the wrap at 255.
	function automatic logic [7:0] pick_pointer();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			return 8'($urandom_range(0, STORE_DEPTH - 1));
		end else if (roll < 85) begin
			return 8'($urandom_range(STORE_DEPTH - 3, STORE_DEPTH + 2));
		end else if (roll < 92) begin
			return 8'($urandom_range(250, 255));
		end
		return 8'($urandom);
	endfunction

	// Offers one event word, waits for it to be taken, records the expected
	// result word, and then applies the sender gap when a burst runs out.
	task automatic send_word(input logic [2:0] code, input logic [7:0] payload,
			input bit typed = 1'b0, input result_word_t want = NO_REPORT);
		result_word_t predicted;
		int unsigned gap;
		event_valid   <= 1'b1;
		func          <= code;
		data_byte     <= payload;
		sender_active = 1'b1;
		@(posedge clk);
		while (event_stall) begin
			@(posedge clk);
		end
		predicted = predict_event(code, payload);
		expected_results.push_back(typed ? want : predicted);
		words_sent++;
		if (bursty) begin
			if (burst_left > 0) begin
				burst_left--;
			end
			if (burst_left == 0) begin
				// The payload is scrambled while valid is low; the block must
				// not look at it.
				gap           = $urandom_range(1, 8);
				event_valid   <= 1'b0;
				func          <= 3'($urandom);
				data_byte     <= 8'($urandom);
				sender_active = 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// Stops sending and waits until every expected result word has arrived.
	// Each event yields a result word, so the block is idle afterwards.
	task automatic hold_until_drained();
		if (sender_active) begin
			event_valid   <= 1'b0;
			sender_active = 1'b0;
		end
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable_reg(input logic value);
		hold_until_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid          <= 1'b0;
		write_enable_model = value;
	endtask

	// Random bus traffic built mostly from well-formed transfers so that the
	// pointer and the byte counter reach every state, with broken sequences
	// and unused event codes mixed in.
	task automatic run_bus_traffic(input int unsigned quota);
		int unsigned stop_at;
		int unsigned kind;
		int unsigned n;
		int unsigned i;
		stop_at = words_sent + quota;
		while (words_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				// Block write: pointer, length, payload bytes, usually a stop.
				send_word(FUNC_ADDR_ACK, 8'($urandom));
				send_word(FUNC_DATA, pick_pointer());
				send_word(FUNC_DATA, 8'($urandom));
				n = $urandom_range(0, 6);
				for (i = 0; i < n; i++) begin
					send_word(FUNC_DATA, 8'($urandom));
				end
				if ($urandom_range(0, 9) != 0) begin
					send_word(FUNC_STOP, 8'($urandom));
				end
			end else if (kind < 50) begin
				// Single-byte command, sometimes followed by a second stop.
				send_word(FUNC_ADDR_ACK, 8'($urandom));
				send_word(FUNC_DATA, 8'($urandom));
				send_word(FUNC_STOP, 8'($urandom));
				if ($urandom_range(0, 4) == 0) begin
					send_word(FUNC_STOP, 8'($urandom));
				end
			end else if (kind < 80) begin
				// Register read: set the pointer, then a run of transmit
				// requests.
				send_word(FUNC_ADDR_ACK, 8'($urandom));
				send_word(FUNC_DATA, pick_pointer());
				if ($urandom_range(0, 1) == 0) begin
					send_word(FUNC_STOP, 8'($urandom));
				end
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					send_word(FUNC_TX_REQ, 8'($urandom));
				end
				send_word(FUNC_STOP, 8'($urandom));
			end else if (kind < 88) begin
				// A transfer cut short by a bus error.
				send_word(FUNC_ADDR_ACK, 8'($urandom));
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++) begin
					send_word(FUNC_DATA, 8'($urandom));
				end
				send_word(FUNC_BUS_ERR, 8'($urandom));
			end else begin
				// Noise: any event code, any payload.
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) begin
					send_word(3'($urandom_range(0, 7)), 8'($urandom));
				end
			end
		end
	endtask

	// Result side: checks each accepted result word against the oldest
	// expectation and drives result_stall from a pattern that changes at random
	// intervals, including stretches with no stall at all.
	always @(posedge clk) begin : result_side
		result_word_t got;
		result_word_t want;
		got = {read_data, read_valid, command_valid, command_code, block_done,
			recover_stop};
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT) begin
					$display("result word %0d arrived with nothing expected: %h",
						results_seen, got);
				end
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					if (mismatch_count < REPORT_LIMIT) begin
						$display("result word %0d mismatch: expected rd=%h rv=%b cv=%b",
							results_seen, want.read_data, want.read_valid,
							want.command_valid,
							" cc=%h bd=%b rs=%b,", want.command_code,
							want.block_done, want.recover_stop,
							" got rd=%h rv=%b cv=%b", got.read_data,
							got.read_valid, got.command_valid,
							" cc=%h bd=%b rs=%b", got.command_code,
							got.block_done, got.recover_stop);
					end
					mismatch_count++;
				end
			end
		end
		if (stall_hold == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_hold <= $urandom_range(50, 300);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_mode)
			STALL_NONE:     result_stall <= 1'b0;
			STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: result_stall <= ((cycle_count % 5) < 2);
			default:        result_stall <= 1'b0;
		endcase
	end

	initial begin
		stim_row_t   directed_rows [DIRECTED_ROWS];
		int unsigned row;
		int unsigned phase;

		// Directed table. The state after reset is pointer 0, counter 0, an
		// all-zero store and write_enable 1.
		directed_rows[0]  = '{FUNC_TX_REQ, 8'h00, 1'b1,
			word_of(8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)};
		directed_rows[1]  = '{FUNC_STOP, 8'hFF, 1'b1, NO_REPORT};
		directed_rows[2]  = '{FUNC_BUS_ERR, 8'h5A, 1'b1,
			word_of(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1)};
		directed_rows[3]  = '{FUNC_OTHER, 8'hFF, 1'b1, NO_REPORT};
		directed_rows[4]  = '{FUNC_OTHER_LAST, 8'h00, 1'b1, NO_REPORT};
		directed_rows[5]  = '{FUNC_ADDR_ACK, 8'hA5, 1'b1, NO_REPORT};
		// Pointer to the last store entry, then a command report and its
		// repeat on a second stop.
		directed_rows[6]  = '{FUNC_DATA, 8'h3F, 1'b1, NO_REPORT};
		directed_rows[7]  = '{FUNC_STOP, 8'h00, 1'b1,
			word_of(8'h00, 1'b0, 1'b1, 8'h3F, 1'b0, 1'b0)};
		directed_rows[8]  = '{FUNC_STOP, 8'h00, 1'b1,
			word_of(8'h00, 1'b0, 1'b1, 8'h3F, 1'b0, 1'b0)};
		// A stop after the length byte reports nothing.
		directed_rows[9]  = '{FUNC_DATA, 8'h20, 1'b1, NO_REPORT};
		directed_rows[10] = '{FUNC_STOP, 8'h00, 1'b1, NO_REPORT};
		// The first byte fills the last entry, the next falls past the store
		// with the counter saturated.
		directed_rows[11] = '{FUNC_DATA, 8'hFF, 1'b0, NO_REPORT};
		directed_rows[12] = '{FUNC_DATA, 8'h00, 1'b0, NO_REPORT};
		directed_rows[13] = '{FUNC_STOP, 8'h00, 1'b1,
			word_of(8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0)};
		// Read back the last entry, then read past the end of the store.
		directed_rows[14] = '{FUNC_ADDR_ACK, 8'h00, 1'b1, NO_REPORT};
		directed_rows[15] = '{FUNC_DATA, 8'h3F, 1'b1, NO_REPORT};
		directed_rows[16] = '{FUNC_TX_REQ, 8'h00, 1'b0, NO_REPORT};
		directed_rows[17] = '{FUNC_TX_REQ, 8'hFF, 1'b1,
			word_of(8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)};
		// Block write from pointer 255: the first byte is dropped and the
		// pointer wraps to zero for the next.
		directed_rows[18] = '{FUNC_ADDR_ACK, 8'h00, 1'b1, NO_REPORT};
		directed_rows[19] = '{FUNC_DATA, 8'hFF, 1'b1, NO_REPORT};
		directed_rows[20] = '{FUNC_DATA, 8'h00, 1'b1, NO_REPORT};
		directed_rows[21] = '{FUNC_DATA, 8'hAA, 1'b0, NO_REPORT};
		directed_rows[22] = '{FUNC_DATA, 8'h55, 1'b0, NO_REPORT};
		directed_rows[23] = '{FUNC_ADDR_ACK, 8'h00, 1'b1, NO_REPORT};
		directed_rows[24] = '{FUNC_DATA, 8'h00, 1'b1, NO_REPORT};
		directed_rows[25] = '{FUNC_TX_REQ, 8'h00, 1'b0, NO_REPORT};

		foreach (store_image[i]) begin
			store_image[i] = 8'h00;
		end
		pointer_model      = 8'h00;
		data_count_model   = 2'd0;
		write_enable_model = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			send_word(directed_rows[row].code, directed_rows[row].payload,
				directed_rows[row].typed, directed_rows[row].want);
		end

		// Random phases alternate write_enable between its extremes, then
		// take random values. Every third phase sends back to back.
		for (phase = 0; phase < PHASES; phase++) begin
			write_enable_reg(phase < 4 ? 1'(phase % 2) : 1'($urandom));
			bursty     = (phase % 3 != 0);
			burst_left = $urandom_range(1, 24);
			if (phase == 2) begin
				// Let the result side run dry once in the middle of a phase.
				run_bus_traffic(WORDS_PER_PHASE / 2);
				hold_until_drained();
				run_bus_traffic(WORDS_PER_PHASE / 2);
			end else begin
				run_bus_traffic(WORDS_PER_PHASE);
			end
		end

		hold_until_drained();
		if (mismatch_count == 0) begin
			$display("smbus_slave_register_file verification clean");
		end else begin
			$display("smbus_slave_register_file verification failed");
		end
		$finish;
	end

endmodule

[smbus_slave_register_file.f]
+incdir+sv
sv/smbus_rf_pkg.sv
sv/smbus_rf_ram.sv
sv/smbus_rf_ctrl.sv
sv/smbus_rf_dp.sv
sv/smbus_slave_register_file.sv
sim/tb.sv
